/* sv/assert_macros.svh */
// assertion macros used by the lttb downsampler
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define CHK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must be followed by another in the next cycle
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/lttb_pkg.sv */
// shared constants, types and helpers of the lttb downsampler
package lttb_pkg;

    localparam int CFG_W             = 15;
    localparam int CFG_IDX_W         = 1;
    localparam int DEF_MAX_SAMPLES   = 16384;
    localparam int DEF_SAMPLE_WIDTH  = 16;
    localparam int MIN_SAMPLES       = 3;
    localparam int ENDPOINT_TARGET   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_COUNT = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

/* sv/lttb_downsampler.sv */
// lttb downsampler top level: sample store, sequencer and shared multiplier
//
//  channel   signals                                  direction
//  sample    in_valid, in_ready, sample_value          in
//  kept      out_valid, out_ready, kept_index,
//            window_done                               out
//  config    cfg_write, cfg_index, cfg_data            in
//
// a plain sample is evaluated by the sequencer before the next one is taken
// a sample that closes a bucket also walks the candidates of the previous
// bucket, each scored on the shared multiplier, and unless that was the last
// bucket makes 3 divider runs for the next bucket bounds
// reset is asynchronous and active low; the sample store is not cleared
// a result waits in the output register, the next sample is taken meanwhile
// a second result of the same sample waits until that register is free
`include "assert_macros.svh"

module lttb_downsampler #(
    parameter int MAX_SAMPLES  = lttb_pkg::DEF_MAX_SAMPLES,
    parameter int SAMPLE_WIDTH = lttb_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [$clog2(MAX_SAMPLES)-1:0] kept_index,
    output logic                           window_done,
    input  logic                           cfg_write,
    input  logic [lttb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lttb_pkg::CFG_W-1:0]     cfg_data
);
    import lttb_pkg::*;

    // widths of indices, sums and the shared multiplier
    localparam int IDX_W = $clog2(MAX_SAMPLES);
    localparam int NB_W  = IDX_W + 1;
    localparam int NW    = imax(CFG_W, NB_W);
    localparam int SX_W  = 2 * IDX_W + 1;
    localparam int SY_W  = SAMPLE_WIDTH + IDX_W + 1;
    localparam int A_W   = 2 * IDX_W + 3;
    localparam int B_W   = SAMPLE_WIDTH + IDX_W + 3;
    localparam int MX_W  = imax(imax(A_W, B_W), NB_W + 1);
    localparam int MY_W  = imax(SAMPLE_WIDTH + 1, NB_W + 1);
    localparam int P_W   = MX_W + MY_W;
    localparam int AR_W  = P_W + 1;
    localparam int DVD_W = 2 * NB_W + 1;
    localparam int QV_W  = NB_W + 1;

    typedef enum logic [17:0] {
        S_IDLE    = 18'h00001,
        S_EVAL    = 18'h00002,
        S_EMIT    = 18'h00004,
        S_SB_MUL  = 18'h00008,
        S_SB_PROD = 18'h00010,
        S_SB_DIV  = 18'h00020,
        S_SB_WAIT = 18'h00040,
        S_PK_A0   = 18'h00080,
        S_PK_A1   = 18'h00100,
        S_PK_A2   = 18'h00200,
        S_PK_RD   = 18'h00400,
        S_PK_M1   = 18'h00800,
        S_PK_M2   = 18'h01000,
        S_PK_M3   = 18'h02000,
        S_PK_VAL  = 18'h04000,
        S_PK_VAL2 = 18'h08000,
        S_AFTER   = 18'h10000,
        S_TAIL    = 18'h20000
    } state_t;

    // configuration
    logic [CFG_W-1:0] sample_count_reg;
    logic [CFG_W-1:0] target_count_reg;

    // sequencer and item state
    state_t                         state_reg;
    state_t                         ret_reg;
    logic [IDX_W-1:0]               cnt_reg;
    logic [IDX_W-1:0]               idx_reg;
    logic signed [SAMPLE_WIDTH-1:0] val_reg;
    logic                           last_reg;
    logic [IDX_W-1:0]               em_idx_reg;
    logic                           em_done_reg;

    // bucket state
    logic [IDX_W-1:0]               bnum_reg;
    logic [NB_W-1:0]                start_reg;
    logic [NB_W-1:0]                split_reg;
    logic [NB_W-1:0]                end_reg;
    logic [SX_W-1:0]                sx_reg;
    logic signed [SY_W-1:0]         sy_reg;
    logic [NB_W-1:0]                cn_reg;
    logic [IDX_W-1:0]               chi_reg;
    logic signed [SAMPLE_WIDTH-1:0] chv_reg;

    // candidate scan
    logic signed [MX_W-1:0]         a_reg;
    logic signed [MX_W-1:0]         b_reg;
    logic [NB_W-1:0]                cand_reg;
    logic [NB_W-1:0]                bi_reg;
    logic [AR_W-1:0]                best_reg;
    logic                           have_reg;
    logic signed [P_W-1:0]          t1_reg;
    logic signed [P_W-1:0]          prod_reg;
    logic [DVD_W-1:0]               mp_reg;
    logic [1:0]                     k_reg;

    // output register
    logic                           out_valid_reg;
    logic [IDX_W-1:0]               kept_index_reg;
    logic                           window_done_reg;

    // sample store
    logic signed [SAMPLE_WIDTH-1:0] mem [MAX_SAMPLES];
    logic signed [SAMPLE_WIDTH-1:0] rd_reg;
    logic                           rd_en;
    logic [IDX_W-1:0]               rd_addr;
    logic                           in_xfer;

    // derived window values
    logic [NW-1:0]                  sc_w;
    logic [NW-1:0]                  n_w;
    logic [NB_W-1:0]                n_eff;
    logic [NB_W-1:0]                m_span;
    logic [CFG_W-1:0]               nb;
    logic                           all_mode;
    logic                           ends_mode;
    logic                           last_now;

    // pick arithmetic
    logic [NB_W-1:0]                c_eff;
    logic [SX_W-1:0]                sx_eff;
    logic signed [SY_W-1:0]         sy_eff;
    logic signed [SAMPLE_WIDTH:0]   dy;
    logic signed [NB_W:0]           pmi;
    logic signed [MX_W-1:0]         mul_x;
    logic signed [MY_W-1:0]         mul_y;
    logic signed [AR_W-1:0]         area;
    logic [AR_W-1:0]                mag;
    logic                           emit_free;

    // divider
    logic                           div_go;
    logic [DVD_W-1:0]               div_dvd;
    div_stat_t                      div_st;
    logic [DVD_W-1:0]               div_quo;
    logic [QV_W-1:0]                q1;

    // clamp the window length to the supported range
    assign sc_w  = NW'(sample_count_reg);
    assign n_w   = (sc_w < NW'(MIN_SAMPLES)) ? NW'(MIN_SAMPLES) :
                   (sc_w > NW'(MAX_SAMPLES)) ? NW'(MAX_SAMPLES) : sc_w;
    assign n_eff = n_w[NB_W-1:0];
    assign m_span = n_eff - NB_W'(2);
    assign nb    = target_count_reg - CFG_W'(ENDPOINT_TARGET);
    assign all_mode  = NW'(target_count_reg) >= n_w;
    assign ends_mode = target_count_reg <= CFG_W'(ENDPOINT_TARGET);
    assign last_now  = (NB_W'(cnt_reg) + NB_W'(1)) >= n_eff;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign emit_free = !out_valid_reg || out_ready;

    // empty following bucket counts as the point (0,0) with unit weight
    assign c_eff  = (cn_reg == '0) ? NB_W'(1) : cn_reg;
    assign sx_eff = (cn_reg == '0) ? '0 : sx_reg;
    assign sy_eff = (cn_reg == '0) ? '0 : sy_reg;
    assign dy     = (SAMPLE_WIDTH+1)'(rd_reg) - (SAMPLE_WIDTH+1)'(chv_reg);
    assign pmi    = $signed({1'b0, NB_W'(chi_reg)}) - $signed({1'b0, cand_reg});
    assign area   = AR_W'(t1_reg) - AR_W'(prod_reg);
    assign mag    = area[AR_W-1] ? AR_W'(-area) : AR_W'(area);

    // operand selection for the shared multiplier
    always_comb
    begin
        mul_x = '0;
        mul_y = '0;
        unique case (state_reg)
            S_PK_A0:
            begin
                mul_x = $signed(MX_W'(c_eff));
                mul_y = $signed(MY_W'(chi_reg));
            end
            S_PK_A1:
            begin
                mul_x = $signed(MX_W'(c_eff));
                mul_y = MY_W'(chv_reg);
            end
            S_PK_M1:
            begin
                mul_x = a_reg;
                mul_y = MY_W'(dy);
            end
            S_PK_M2:
            begin
                mul_x = b_reg;
                mul_y = MY_W'(pmi);
            end
            S_SB_MUL:
            begin
                mul_x = $signed(MX_W'(m_span));
                mul_y = $signed(MY_W'(bnum_reg));
            end
            default:
            begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= P_W'(mul_x * mul_y);
    end

    // bound numerator (b+k)*m, divided by the bucket count
    assign div_go  = (state_reg == S_SB_DIV);
    always_comb
    begin
        case (k_reg)
            2'd0:    div_dvd = mp_reg;
            2'd1:    div_dvd = mp_reg + DVD_W'(m_span);
            default: div_dvd = mp_reg + DVD_W'(m_span) + DVD_W'(m_span);
        endcase
    end

    lttb_div #(
        .DVD_W (DVD_W),
        .DVS_W (CFG_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go),
        .dividend (div_dvd),
        .divisor  (nb),
        .stat     (div_st),
        .quotient (div_quo)
    );

    assign q1 = div_quo[QV_W-1:0] + QV_W'(1);

    // sample store, one write and one registered read port
    assign rd_en   = (state_reg == S_PK_RD) || (state_reg == S_PK_VAL);
    assign rd_addr = (state_reg == S_PK_VAL) ? bi_reg[IDX_W-1:0] : cand_reg[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            mem[cnt_reg] <= sample_value;
        end
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= CFG_W'(16384);
            target_count_reg <= CFG_W'(ENDPOINT_TARGET);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SAMPLE_COUNT: sample_count_reg <= cfg_data;
                REG_TARGET_COUNT: target_count_reg <= cfg_data;
            endcase
        end
    end

    // main sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            ret_reg         <= S_IDLE;
            cnt_reg         <= '0;
            idx_reg         <= '0;
            val_reg         <= '0;
            last_reg        <= 1'b0;
            em_idx_reg      <= '0;
            em_done_reg     <= 1'b0;
            bnum_reg        <= '0;
            start_reg       <= NB_W'(1);
            split_reg       <= '0;
            end_reg         <= '0;
            sx_reg          <= '0;
            sy_reg          <= '0;
            cn_reg          <= '0;
            chi_reg         <= '0;
            chv_reg         <= '0;
            a_reg           <= '0;
            b_reg           <= '0;
            cand_reg        <= '0;
            bi_reg          <= '0;
            best_reg        <= '0;
            t1_reg          <= '0;
            mp_reg          <= '0;
            out_valid_reg   <= 1'b0;
            kept_index_reg  <= '0;
            window_done_reg <= 1'b0;
            k_reg           <= '0;
            have_reg        <= 1'b0;
        end
        else
        begin
            // the emit state loads the register itself when it is free
            if (out_ready && !((state_reg == S_EMIT) && emit_free))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        idx_reg   <= cnt_reg;
                        val_reg   <= sample_value;
                        last_reg  <= last_now;
                        cnt_reg   <= last_now ? '0 : cnt_reg + IDX_W'(1);
                        state_reg <= S_EVAL;
                    end
                end

                S_EVAL:
                begin
                    if (all_mode)
                    begin
                        em_idx_reg  <= idx_reg;
                        em_done_reg <= last_reg;
                        ret_reg     <= S_IDLE;
                        state_reg   <= S_EMIT;
                    end
                    else if (ends_mode)
                    begin
                        em_idx_reg  <= idx_reg;
                        em_done_reg <= last_reg;
                        ret_reg     <= S_IDLE;
                        state_reg   <= ((idx_reg == '0) || last_reg) ? S_EMIT : S_IDLE;
                    end
                    else if (idx_reg == '0)
                    begin
                        // window start: first point is kept, first bucket set up
                        bnum_reg    <= '0;
                        chi_reg     <= '0;
                        chv_reg     <= val_reg;
                        em_idx_reg  <= '0;
                        em_done_reg <= 1'b0;
                        ret_reg     <= S_SB_MUL;
                        state_reg   <= S_EMIT;
                    end
                    else
                    begin
                        if ((NB_W'(idx_reg) >= split_reg) && (NB_W'(idx_reg) < end_reg))
                        begin
                            sx_reg <= sx_reg + SX_W'(idx_reg);
                            sy_reg <= sy_reg + SY_W'(val_reg);
                            cn_reg <= cn_reg + NB_W'(1);
                        end
                        if ((NW'(bnum_reg) < NW'(nb)) &&
                            ((NB_W'(idx_reg) + NB_W'(1)) == end_reg))
                        begin
                            state_reg <= S_PK_A0;
                        end
                        else
                        begin
                            state_reg <= S_TAIL;
                        end
                    end
                end

                S_EMIT:
                begin
                    if (emit_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        kept_index_reg  <= em_idx_reg;
                        window_done_reg <= em_done_reg;
                        state_reg       <= ret_reg;
                    end
                end

                // bucket bounds: b*m once, then three divisions
                S_SB_MUL:
                begin
                    state_reg <= S_SB_PROD;
                end

                S_SB_PROD:
                begin
                    mp_reg    <= prod_reg[DVD_W-1:0];
                    k_reg     <= '0;
                    state_reg <= S_SB_DIV;
                end

                S_SB_DIV:
                begin
                    state_reg <= S_SB_WAIT;
                end

                S_SB_WAIT:
                begin
                    if (div_st.done)
                    begin
                        case (k_reg)
                            2'd0:
                            begin
                                start_reg <= q1[NB_W-1:0];
                            end
                            2'd1:
                            begin
                                split_reg <= (q1 < QV_W'(n_eff - NB_W'(1))) ?
                                             q1[NB_W-1:0] : n_eff - NB_W'(1);
                            end
                            default:
                            begin
                                end_reg <= (q1 < QV_W'(n_eff)) ? q1[NB_W-1:0] : n_eff;
                            end
                        endcase
                        if (k_reg == 2'd2)
                        begin
                            sx_reg    <= '0;
                            sy_reg    <= '0;
                            cn_reg    <= '0;
                            state_reg <= S_TAIL;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 2'd1;
                            state_reg <= S_SB_DIV;
                        end
                    end
                end

                // per bucket terms c*p - sx and sy - c*yp
                S_PK_A0:
                begin
                    state_reg <= S_PK_A1;
                end

                S_PK_A1:
                begin
                    a_reg     <= MX_W'(prod_reg) - $signed(MX_W'(sx_eff));
                    state_reg <= S_PK_A2;
                end

                S_PK_A2:
                begin
                    b_reg     <= MX_W'(sy_eff) - MX_W'(prod_reg);
                    cand_reg  <= start_reg;
                    bi_reg    <= start_reg;
                    best_reg  <= '0;
                    have_reg  <= 1'b0;
                    state_reg <= S_PK_RD;
                end

                // candidate walk, earliest index wins a tie
                S_PK_RD:
                begin
                    state_reg <= (cand_reg < split_reg) ? S_PK_M1 : S_PK_VAL;
                end

                S_PK_M1:
                begin
                    state_reg <= S_PK_M2;
                end

                S_PK_M2:
                begin
                    t1_reg    <= prod_reg;
                    state_reg <= S_PK_M3;
                end

                S_PK_M3:
                begin
                    if (!have_reg || (mag > best_reg))
                    begin
                        best_reg <= mag;
                        bi_reg   <= cand_reg;
                        have_reg <= 1'b1;
                    end
                    cand_reg  <= cand_reg + NB_W'(1);
                    state_reg <= S_PK_RD;
                end

                S_PK_VAL:
                begin
                    state_reg <= S_PK_VAL2;
                end

                S_PK_VAL2:
                begin
                    chi_reg     <= bi_reg[IDX_W-1:0];
                    chv_reg     <= rd_reg;
                    em_idx_reg  <= bi_reg[IDX_W-1:0];
                    em_done_reg <= 1'b0;
                    ret_reg     <= S_AFTER;
                    state_reg   <= S_EMIT;
                end

                S_AFTER:
                begin
                    bnum_reg  <= bnum_reg + IDX_W'(1);
                    state_reg <= ((NW'(bnum_reg) + NW'(1)) < NW'(nb)) ? S_SB_MUL : S_TAIL;
                end

                S_TAIL:
                begin
                    em_idx_reg  <= idx_reg;
                    em_done_reg <= 1'b1;
                    ret_reg     <= S_IDLE;
                    state_reg   <= last_reg ? S_EMIT : S_IDLE;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign kept_index  = kept_index_reg;
    assign window_done = window_done_reg;

    `CHK_NEXT(a_emit_loads, (state_reg == S_EMIT) && !out_valid_reg, out_valid_reg, "emit lost")
    `CHK(a_div_start_idle, div_go |-> !div_st.busy, "divider restarted while busy")
    `CHK(a_bounds_order, (state_reg == S_IDLE) |-> (split_reg <= end_reg), "bounds out of order")

endmodule

/* sv/lttb_div.sv */
// restoring divider, one quotient bit per cycle
module lttb_div #(
    parameter int DVD_W = 31,
    parameter int DVS_W = 15
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DVD_W-1:0]    dividend,
    input  logic [DVS_W-1:0]    divisor,
    output lttb_pkg::div_stat_t stat,
    output logic [DVD_W-1:0]    quotient
);
    import lttb_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W:0]   rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVS_W:0]   rem_sh;
    logic [DVS_W+1:0] diff;
    logic             ge;

    assign rem_sh = {rem_reg[DVS_W-1:0], quo_reg[DVD_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, divisor};
    assign ge     = !diff[DVS_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DVD_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
            rem_reg <= ge ? diff[DVS_W:0] : rem_sh;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule
